>>> hdl/bvs_pkg.sv
// Package for the bounded value set: capacity, codes and cell control type.
`timescale 1ns / 1ps

package bvs_pkg;

  localparam int unsigned SET_CAPACITY = 16;
  localparam int unsigned OCC_W = $clog2(SET_CAPACITY + 1);
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_LOOKUP = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_NOT_DONE = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  // Per-request control broadcast to every cell.
  typedef struct packed {
    logic insert_go;
    logic erase_go;
  } cell_ctrl_t;

endpackage

>>> hdl/bvs_cell.sv
// One storage cell of the set: holds an entry, compares it and shifts from its neighbor.
`timescale 1ns / 1ps

module bvs_cell import bvs_pkg::*; (
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  logic [VALUE_W-1:0] key_i,
  input  logic               occupied_i,
  input  logic               ins_here_i,
  input  logic               match_i,
  input  logic [VALUE_W-1:0] next_entry_i,
  output logic               match_o,
  output logic [VALUE_W-1:0] entry_o
);

  logic [VALUE_W-1:0] entry_q, entry_d;
  logic               hit;

  assign hit     = occupied_i && (entry_q == key_i);
  assign match_o = match_i || hit;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    // shift down from the neighbor at and above the erased position
    if (ctrl_i.erase_go && match_o) begin
      entry_d = next_entry_i;
    end else if (ctrl_i.insert_go && ins_here_i) begin
      entry_d = key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> hdl/bounded_value_set_unit.sv
// Top level of the bounded value set: stream ports, occupancy count and the row of cells.
`timescale 1ns / 1ps

// A set of up to SET_CAPACITY distinct 32-bit values. Each request word carries an
// opcode (insert, erase, look up) and a value; each gives one result word with a status
// (done/found, not done, full) and the count held afterwards. For each request the
// value is compared in every cell at once, a match chain running through the row
// finds the first hit, and an erase shifts later entries down by one in the same edge.
// The result is registered, and a new request is taken every cycle while the result
// side keeps up; the match chain through the cells sets the clock period. No clearing
// pass is needed after reset.
module bounded_value_set_unit import bvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // [1:0] opcode, [33:2] value, [39:34] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o   // [1:0] status, [6:2] count, [7] zero
);

  logic [OCC_W-1:0]    occ_q, occ_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [COUNT_W-1:0]  count_q, count_d;

  logic               accept;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0] key;
  logic               found;
  logic               full;
  cell_ctrl_t         ctrl;

  logic [VALUE_W-1:0] entry_w [SET_CAPACITY];
  logic [SET_CAPACITY:0] chain_w;

  assign opcode = s_axis_tdata_i[1:0];
  assign key    = s_axis_tdata_i[33:2];
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign full   = (occ_q == OCC_W'(SET_CAPACITY));

  assign chain_w[0] = 1'b0;
  assign found      = chain_w[SET_CAPACITY];

  assign ctrl.insert_go = accept && (opcode == OP_INSERT) && !found && !full;
  assign ctrl.erase_go  = accept && (opcode == OP_ERASE) && found;

  for (genvar i = 0; i < SET_CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] next_entry;
    if (i == SET_CAPACITY - 1) begin : g_last
      assign next_entry = entry_w[i];
    end else begin : g_mid
      assign next_entry = entry_w[i+1];
    end

    bvs_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .key_i        (key),
      .occupied_i   (occ_q > OCC_W'(i)),
      .ins_here_i   (occ_q == OCC_W'(i)),
      .match_i      (chain_w[i]),
      .next_entry_i (next_entry),
      .match_o      (chain_w[i+1]),
      .entry_o      (entry_w[i])
    );
  end

  always_comb begin
    occ_d       = occ_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    count_d     = count_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      status_d    = ST_NOT_DONE;
      unique case (opcode)
        OP_INSERT: begin
          priority if (found) begin
            status_d = ST_NOT_DONE;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            status_d = ST_DONE;
            occ_d    = occ_q + OCC_W'(1);
          end
        end
        OP_ERASE: begin
          if (found) begin
            status_d = ST_DONE;
            occ_d    = occ_q - OCC_W'(1);
          end
        end
        OP_LOOKUP: begin
          status_d = found ? ST_DONE : ST_NOT_DONE;
        end
        default: begin
          status_d = ST_NOT_DONE;
        end
      endcase
      count_d = COUNT_W'(occ_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    count_q  <= count_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, count_q, status_q};

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(SET_CAPACITY))
    else $error("occupancy above capacity");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (status_d == ST_FULL) |-> full && (opcode == OP_INSERT))
    else $error("full status without a full set");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert_go |=> occ_q == $past(occ_q) + OCC_W'(1))
    else $error("insert did not grow the set");

  a_erase_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.erase_go |=> occ_q == $past(occ_q) - OCC_W'(1))
    else $error("erase did not shrink the set");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o && (count_q == COUNT_W'(occ_q)))
    else $error("result word missing or count stale");
`endif

endmodule
